/* rtl/introsort_u32_dedup_top_assert.svh */
// Assertion macros used by the sorter top file.
`ifndef INTROSORT_U32_DEDUP_TOP_ASSERT_SVH
`define INTROSORT_U32_DEDUP_TOP_ASSERT_SVH

// A property that must hold in the same cycle.
`define ISO_ASSERT_NOW(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An antecedent that forces a consequent in the next cycle.
`define ISO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/iso_pkg.sv */
`timescale 1ns / 1ps
package iso_pkg;

   localparam int DEPTH_DEF  = 64;
   localparam int CUTOFF_DEF = 4;
   localparam int VAL_W      = 32;
   localparam int KEPT_W     = 7;

   typedef struct packed {
      logic loading;
      logic sorting;
      logic emitting;
      logic stack_ovf;
   } iso_stat_type;

endpackage

/* rtl/iso_if.sv */
`timescale 1ns / 1ps
interface iso_req_if import iso_pkg::*;;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] value;
   logic             last_item;

   modport source (output valid, value, last_item, input ready);
   modport sink (input valid, value, last_item, output ready);
endinterface

interface iso_rsp_if import iso_pkg::*;;
   logic              valid;
   logic              ready;
   logic [VAL_W-1:0]  sorted_value;
   logic              last_result;
   logic [KEPT_W-1:0] kept_count;
   logic              overflow;

   modport source (output valid, sorted_value, last_result, kept_count, overflow, input ready);
   modport sink (input valid, sorted_value, last_result, kept_count, overflow, output ready);
endinterface

/* rtl/iso_store.sv */
`timescale 1ns / 1ps
module iso_store import iso_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [VAL_W-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [VAL_W-1:0] rdata
);

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/iso_engine.sv */
`timescale 1ns / 1ps
module iso_engine import iso_pkg::*; #(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int SMALL_CUTOFF = CUTOFF_DEF,
   parameter int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   iso_req_if.sink          req_ch,
   iso_rsp_if.source        rsp_ch,
   output logic             mem_we,
   output logic [AW-1:0]    mem_waddr,
   output logic [VAL_W-1:0] mem_wdata,
   output logic [AW-1:0]    mem_raddr,
   input  logic [VAL_W-1:0] mem_rdata,
   output iso_stat_type     stat
);

   localparam int LW  = $clog2(DEPTH + 1);
   localparam int CW  = LW + 1;
   localparam int BW  = $clog2(AW + 1);
   localparam int SD  = AW + 2;
   localparam int SPW = $clog2(SD + 1);
   localparam int IW  = $clog2(SD);

   typedef enum logic [34:0] {
      S_LOAD   = 35'b1 << 0,  S_START  = 35'b1 << 1,  S_POP    = 35'b1 << 2,
      S_PV0    = 35'b1 << 3,  S_PV1    = 35'b1 << 4,  S_PV2    = 35'b1 << 5,
      S_PV3    = 35'b1 << 6,  S_SI_RD  = 35'b1 << 7,  S_SI_CK  = 35'b1 << 8,
      S_SJ_RD  = 35'b1 << 9,  S_SJ_CK  = 35'b1 << 10, S_SW2    = 35'b1 << 11,
      S_PUSH   = 35'b1 << 12, S_HS_INI = 35'b1 << 13, S_HS_SWP = 35'b1 << 14,
      S_HS_S1  = 35'b1 << 15, S_HS_S2  = 35'b1 << 16, S_HS_S3  = 35'b1 << 17,
      S_SD_ST  = 35'b1 << 18, S_SD_D   = 35'b1 << 19, S_SD_LP  = 35'b1 << 20,
      S_SD_C1  = 35'b1 << 21, S_SD_C2  = 35'b1 << 22, S_SD_CMP = 35'b1 << 23,
      S_SD_END = 35'b1 << 24, S_SD_RET = 35'b1 << 25, S_IN_RD  = 35'b1 << 26,
      S_IN_T   = 35'b1 << 27, S_IN_SH  = 35'b1 << 28, S_IN_SC  = 35'b1 << 29,
      S_IN_WR  = 35'b1 << 30, S_EM_RD  = 35'b1 << 31, S_EM_V   = 35'b1 << 32,
      S_EM_W   = 35'b1 << 33, S_IDLE2  = 35'b1 << 34
   } state_type;

   state_type        state_ff, state_in;
   logic [LW-1:0]    cnt_ff, cnt_in, n_ff, n_in;
   logic             ovf_ff, ovf_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic [AW-1:0]    stk_base_ff [SD];
   logic [AW-1:0]    stk_base_in [SD];
   logic [LW-1:0]    stk_len_ff [SD];
   logic [LW-1:0]    stk_len_in [SD];
   logic [BW-1:0]    stk_bud_ff [SD];
   logic [BW-1:0]    stk_bud_in [SD];
   logic [AW-1:0]    base_ff, base_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [BW-1:0]    bud_ff, bud_in;
   logic [LW-1:0]    i_ff, i_in, j_ff, j_in, hk_ff, hk_in, kk_ff, kk_in;
   logic [LW-1:0]    pos_ff, pos_in, hl_ff, hl_in;
   logic [CW-1:0]    c_ff, c_in;
   logic             build_ff, build_in;
   logic [VAL_W-1:0] piv_ff, piv_in, x_ff, x_in, y_ff, y_in, d_ff, d_in;
   logic [VAL_W-1:0] maxv_ff, maxv_in, prev_ff, prev_in;
   logic             ov_ff, ov_in, olast_ff, olast_in;
   logic [VAL_W-1:0] oval_ff, oval_in;

   logic [LW-1:0]    rd_off, wr_off;
   logic [BW-1:0]    n_bud;
   logic [IW-1:0]    top_idx, push0_idx, push1_idx;
   logic [CW-1:0]    c_dbl;

   assign top_idx   = IW'(sp_ff - SPW'(1));
   assign push0_idx = IW'(sp_ff);
   assign push1_idx = IW'(sp_ff + SPW'(1));
   assign c_dbl     = {pos_ff, 1'b0};

   always_comb begin
      n_bud = '0;
      for (int b = 1; b < LW; b++) begin
         if (n_ff[b]) begin
            n_bud = BW'(b);
         end
      end
   end

   assign mem_raddr = base_ff + rd_off[AW-1:0];
   assign mem_waddr = base_ff + wr_off[AW-1:0];

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      ovf_in      = ovf_ff;
      sp_in       = sp_ff;
      stk_base_in = stk_base_ff;
      stk_len_in  = stk_len_ff;
      stk_bud_in  = stk_bud_ff;
      base_in     = base_ff;
      len_in      = len_ff;
      bud_in      = bud_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      hk_in       = hk_ff;
      kk_in       = kk_ff;
      pos_in      = pos_ff;
      hl_in       = hl_ff;
      c_in        = c_ff;
      build_in    = build_ff;
      piv_in      = piv_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      d_in        = d_ff;
      maxv_in     = maxv_ff;
      prev_in     = prev_ff;
      ov_in       = ov_ff;
      olast_in    = olast_ff;
      oval_in     = oval_ff;
      rd_off      = '0;
      wr_off      = '0;
      mem_we      = 1'b0;
      mem_wdata   = x_ff;
      req_ch.ready = 1'b0;

      case (state_ff)
         S_LOAD: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (int'(cnt_ff) < DEPTH) begin
                  mem_we    = 1'b1;
                  wr_off    = cnt_ff;
                  mem_wdata = req_ch.value;
                  cnt_in    = cnt_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last_item) begin
                  n_in     = cnt_in;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            stk_base_in[0] = '0;
            stk_len_in[0]  = n_ff;
            stk_bud_in[0]  = n_bud;
            sp_in          = SPW'(1);
            state_in       = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               base_in  = '0;
               i_in     = '0;
               kk_in    = '0;
               state_in = S_IN_RD;
            end else begin
               sp_in   = sp_ff - SPW'(1);
               base_in = stk_base_ff[top_idx];
               len_in  = stk_len_ff[top_idx];
               bud_in  = stk_bud_ff[top_idx];
               if (int'(stk_len_ff[top_idx]) <= SMALL_CUTOFF) begin
                  state_in = S_POP;
               end else if (stk_bud_ff[top_idx] == '0) begin
                  state_in = S_HS_INI;
               end else begin
                  state_in = S_PV0;
               end
            end
         end
         S_PV0: begin
            rd_off   = '0;
            state_in = S_PV1;
         end
         S_PV1: begin
            x_in     = mem_rdata;
            rd_off   = (len_ff >> 1) + LW'(1);
            state_in = S_PV2;
         end
         S_PV2: begin
            y_in     = mem_rdata;
            rd_off   = len_ff - LW'(1);
            state_in = S_PV3;
         end
         S_PV3: begin
            if (y_ff < x_ff) begin
               piv_in = (mem_rdata < y_ff) ? y_ff : ((mem_rdata < x_ff) ? mem_rdata : x_ff);
            end else begin
               piv_in = (mem_rdata < y_ff) ? ((mem_rdata < x_ff) ? x_ff : mem_rdata) : y_ff;
            end
            i_in     = '0;
            j_in     = len_ff;
            state_in = S_SI_RD;
         end
         S_SI_RD: begin
            rd_off   = i_ff;
            state_in = S_SI_CK;
         end
         S_SI_CK: begin
            if ((i_ff + LW'(1) < len_ff) && (mem_rdata < piv_ff)) begin
               i_in     = i_ff + LW'(1);
               state_in = S_SI_RD;
            end else begin
               x_in = mem_rdata;
               if (j_ff == '0) begin
                  state_in = S_PUSH;
               end else begin
                  j_in     = j_ff - LW'(1);
                  state_in = S_SJ_RD;
               end
            end
         end
         S_SJ_RD: begin
            rd_off   = j_ff;
            state_in = S_SJ_CK;
         end
         S_SJ_CK: begin
            if ((j_ff != '0) && (piv_ff < mem_rdata)) begin
               j_in     = j_ff - LW'(1);
               state_in = S_SJ_RD;
            end else if (!(i_ff < j_ff)) begin
               state_in = S_PUSH;
            end else begin
               mem_we    = 1'b1;
               wr_off    = i_ff;
               mem_wdata = mem_rdata;
               state_in  = S_SW2;
            end
         end
         S_SW2: begin
            mem_we    = 1'b1;
            wr_off    = j_ff;
            mem_wdata = x_ff;
            i_in      = i_ff + LW'(1);
            state_in  = S_SI_RD;
         end
         S_PUSH: begin
            stk_base_in[push0_idx] = base_ff + i_ff[AW-1:0];
            stk_len_in[push0_idx]  = len_ff - i_ff;
            stk_bud_in[push0_idx]  = bud_ff - BW'(1);
            stk_base_in[push1_idx] = base_ff;
            stk_len_in[push1_idx]  = i_ff;
            stk_bud_in[push1_idx]  = bud_ff - BW'(1);
            sp_in                  = sp_ff + SPW'(2);
            state_in               = S_POP;
         end
         S_HS_INI: begin
            hk_in    = len_ff >> 1;
            pos_in   = len_ff >> 1;
            hl_in    = len_ff;
            build_in = 1'b1;
            state_in = S_SD_ST;
         end
         S_HS_SWP: begin
            if (hk_ff <= LW'(1)) begin
               state_in = S_POP;
            end else begin
               rd_off   = '0;
               state_in = S_HS_S1;
            end
         end
         S_HS_S1: begin
            x_in     = mem_rdata;
            rd_off   = hk_ff - LW'(1);
            state_in = S_HS_S2;
         end
         S_HS_S2: begin
            mem_we    = 1'b1;
            wr_off    = '0;
            mem_wdata = mem_rdata;
            state_in  = S_HS_S3;
         end
         S_HS_S3: begin
            mem_we    = 1'b1;
            wr_off    = hk_ff - LW'(1);
            mem_wdata = x_ff;
            pos_in    = LW'(1);
            hl_in     = hk_ff - LW'(1);
            state_in  = S_SD_ST;
         end
         S_SD_ST: begin
            rd_off   = pos_ff - LW'(1);
            state_in = S_SD_D;
         end
         S_SD_D: begin
            d_in     = mem_rdata;
            state_in = S_SD_LP;
         end
         S_SD_LP: begin
            c_in = c_dbl;
            if (c_dbl > {1'b0, hl_ff}) begin
               state_in = S_SD_END;
            end else begin
               rd_off   = LW'(c_dbl - CW'(1));
               state_in = S_SD_C1;
            end
         end
         S_SD_C1: begin
            x_in = mem_rdata;
            if (c_ff < {1'b0, hl_ff}) begin
               rd_off   = LW'(c_ff);
               state_in = S_SD_C2;
            end else begin
               y_in     = mem_rdata;
               state_in = S_SD_CMP;
            end
         end
         S_SD_C2: begin
            if (x_ff < mem_rdata) begin
               y_in = mem_rdata;
               c_in = c_ff + CW'(1);
            end else begin
               y_in = x_ff;
            end
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            if (!(d_ff < y_ff)) begin
               state_in = S_SD_END;
            end else begin
               mem_we    = 1'b1;
               wr_off    = pos_ff - LW'(1);
               mem_wdata = y_ff;
               pos_in    = LW'(c_ff);
               state_in  = S_SD_LP;
            end
         end
         S_SD_END: begin
            mem_we    = 1'b1;
            wr_off    = pos_ff - LW'(1);
            mem_wdata = d_ff;
            state_in  = S_SD_RET;
         end
         S_SD_RET: begin
            if (build_ff) begin
               if (hk_ff == LW'(1)) begin
                  build_in = 1'b0;
                  hk_in    = len_ff;
                  state_in = S_HS_SWP;
               end else begin
                  hk_in    = hk_ff - LW'(1);
                  pos_in   = hk_ff - LW'(1);
                  hl_in    = len_ff;
                  state_in = S_SD_ST;
               end
            end else begin
               hk_in    = hk_ff - LW'(1);
               state_in = S_HS_SWP;
            end
         end
         S_IN_RD: begin
            if (i_ff == n_ff) begin
               i_in     = '0;
               state_in = S_EM_RD;
            end else begin
               rd_off   = i_ff;
               state_in = S_IN_T;
            end
         end
         S_IN_T: begin
            d_in = mem_rdata;
            if ((kk_ff != '0) && ((mem_rdata == maxv_ff) || (mem_rdata == prev_ff))) begin
               i_in     = i_ff + LW'(1);
               state_in = S_IN_RD;
            end else begin
               j_in     = kk_ff;
               state_in = S_IN_SH;
            end
         end
         S_IN_SH: begin
            if (j_ff != '0) begin
               rd_off   = j_ff - LW'(1);
               state_in = S_IN_SC;
            end else begin
               state_in = S_IN_WR;
            end
         end
         S_IN_SC: begin
            if (d_ff < mem_rdata) begin
               mem_we    = 1'b1;
               wr_off    = j_ff;
               mem_wdata = mem_rdata;
               j_in      = j_ff - LW'(1);
               state_in  = S_IN_SH;
            end else begin
               state_in = S_IN_WR;
            end
         end
         S_IN_WR: begin
            mem_we    = 1'b1;
            wr_off    = j_ff;
            mem_wdata = d_ff;
            prev_in   = d_ff;
            if ((kk_ff == '0) || (maxv_ff < d_ff)) begin
               maxv_in = d_ff;
            end
            kk_in    = kk_ff + LW'(1);
            i_in     = i_ff + LW'(1);
            state_in = S_IN_RD;
         end
         S_EM_RD: begin
            rd_off   = i_ff;
            state_in = S_EM_V;
         end
         S_EM_V: begin
            ov_in    = 1'b1;
            oval_in  = mem_rdata;
            olast_in = (i_ff + LW'(1) == kk_ff);
            state_in = S_EM_W;
         end
         S_EM_W: begin
            if (rsp_ch.ready) begin
               ov_in = 1'b0;
               i_in  = i_ff + LW'(1);
               if (olast_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_EM_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
         base_ff  <= '0;
         build_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
         base_ff  <= base_in;
         build_ff <= build_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      stk_base_ff <= stk_base_in;
      stk_len_ff  <= stk_len_in;
      stk_bud_ff  <= stk_bud_in;
      n_ff        <= n_in;
      len_ff      <= len_in;
      bud_ff      <= bud_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      hk_ff       <= hk_in;
      kk_ff       <= kk_in;
      pos_ff      <= pos_in;
      hl_ff       <= hl_in;
      c_ff        <= c_in;
      piv_ff      <= piv_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      d_ff        <= d_in;
      maxv_ff     <= maxv_in;
      prev_ff     <= prev_in;
      olast_ff    <= olast_in;
      oval_ff     <= oval_in;
   end

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.sorted_value = oval_ff;
   assign rsp_ch.last_result  = olast_ff;
   assign rsp_ch.kept_count   = KEPT_W'(kk_ff);
   assign rsp_ch.overflow     = ovf_ff;

   assign stat.loading   = (state_ff == S_LOAD);
   assign stat.emitting  = (state_ff == S_EM_RD) || (state_ff == S_EM_V) || (state_ff == S_EM_W);
   assign stat.sorting   = !stat.loading && !stat.emitting;
   assign stat.stack_ovf = (state_ff == S_PUSH) && (int'(sp_ff) > SD - 2);

endmodule

/* rtl/introsort_u32_dedup_top.sv */
`timescale 1ns / 1ps
// Channel  Dir  Fields                                            Handshake
// req_ch   in   value[31:0], last_item                            valid/ready
// rsp_ch   out  sorted_value[31:0], last_result, kept_count[6:0],
//               overflow                                          valid/ready
//
// Loading takes one word per cycle; the word marked last_item starts the sort.
// Sorting runs out of one storage array with one read and one write port and
// a registered read port, using quicksort or heapsort followed by an
// insertion pass. Each result word is read out, then held on rsp_ch until
// rsp_ch.ready takes it, before the next word is read.
// Reset clears the control state only; no input word is taken while sorting
// or emitting.
module introsort_u32_dedup_top import iso_pkg::*; #(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int SMALL_CUTOFF = CUTOFF_DEF
) (
   input logic       clock,
   input logic       reset,
   iso_req_if.sink   req_ch,
   iso_rsp_if.source rsp_ch
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [VAL_W-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [VAL_W-1:0] mem_rdata;
   iso_stat_type     stat;

   iso_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   iso_engine #(.DEPTH(DEPTH), .SMALL_CUTOFF(SMALL_CUTOFF), .AW(AW)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .stat      (stat)
   );

`include "introsort_u32_dedup_top_assert.svh"

   `ISO_ASSERT_NOW(a_load_emit_excl, clock, reset, !(req_ch.ready && rsp_ch.valid), "load and emit overlap")
   `ISO_ASSERT_NOW(a_stack_depth, clock, reset, !stat.stack_ovf, "partition stack overflow")
   `ISO_ASSERT_NEXT(a_last_to_load, clock, reset, rsp_ch.valid && rsp_ch.ready && rsp_ch.last_result, stat.loading, "no return to loading after last word")

endmodule

/* dv/introsort_u32_dedup_top_test.sv */
`timescale 1ns / 1ps
module introsort_u32_dedup_top_test;
   import iso_pkg::*;

   typedef struct {
      logic [VAL_W-1:0] value;
      logic             last_item;
      bit               typed;
      logic [VAL_W-1:0] sorted_value;
      logic [KEPT_W-1:0] kept_count;
      logic             overflow;
   } stim_row_type;

   typedef struct {
      logic [VAL_W-1:0]  sorted_value;
      logic              last_result;
      logic [KEPT_W-1:0] kept_count;
      logic              overflow;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   iso_req_if req_ch ();
   iso_rsp_if rsp_ch ();

   introsort_u32_dedup_top dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [VAL_W-1:0] held_values [DEPTH_DEF];
   int unsigned      held_count;
   bit               dropped_extra;
   sorted_word_type  expected_words [$];
   int               error_count = 0;
   bit               quiet_sink = 1'b0;
   bit               hold_sink = 1'b0;
   int               hold_cycles = 0;
   stim_row_type     rows [$];

   function automatic void heap_sift(ref logic [VAL_W-1:0] v[DEPTH_DEF], input int base,
                                     input int pos, input int len);
      logic [VAL_W-1:0] d;
      int c;
      d = v[base+pos-1];
      while (pos * 2 <= len) begin
         c = pos * 2;
         if (c < len && v[base+c-1] < v[base+c]) c++;
         if (!(d < v[base+c-1])) break;
         v[base+pos-1] = v[base+c-1];
         pos = c;
      end
      v[base+pos-1] = d;
   endfunction

   function automatic void range_sort(ref logic [VAL_W-1:0] v[DEPTH_DEF], input int base,
                                      input int len, input int budget);
      logic [VAL_W-1:0] lo, mid, hi, piv, t;
      int i, j, p;
      if (len <= CUTOFF_DEF) return;
      if (budget == 0) begin
         for (int k = len / 2; k >= 1; k--) heap_sift(v, base, k, len);
         for (int k = len; k > 1; k--) begin
            t = v[base]; v[base] = v[base+k-1]; v[base+k-1] = t;
            heap_sift(v, base, 1, k - 1);
         end
         return;
      end
      lo = v[base]; mid = v[base+len/2+1]; hi = v[base+len-1];
      if (mid < lo) piv = (hi < mid) ? mid : ((hi < lo) ? hi : lo);
      else piv = (hi < mid) ? ((hi < lo) ? lo : hi) : mid;
      i = 0; j = len;
      forever begin
         while (i + 1 < len && v[base+i] < piv) i++;
         if (j == 0) break;
         j--;
         while (j > 0 && piv < v[base+j]) j--;
         if (!(i < j)) break;
         t = v[base+i]; v[base+i] = v[base+j]; v[base+j] = t;
         i++;
      end
      p = i;
      if (len - p < p) begin
         range_sort(v, base + p, len - p, budget - 1);
         range_sort(v, base, p, budget - 1);
      end else begin
         range_sort(v, base, p, budget - 1);
         range_sort(v, base + p, len - p, budget - 1);
      end
   endfunction

   function automatic void accept_value(logic [VAL_W-1:0] value, logic last_item);
      int n, kept, budget, j;
      logic [VAL_W-1:0] t, prev;
      sorted_word_type w;
      if (held_count < DEPTH_DEF) held_values[held_count++] = value;
      else dropped_extra = 1'b1;
      if (!last_item) return;
      n = held_count;
      kept = n;
      if (n >= 2) begin
         budget = 0;
         for (int k = n; k > 1; k >>= 1) budget++;
         range_sort(held_values, 0, n, budget);
         kept = 0;
         prev = '0;
         for (int i = 0; i < n; i++) begin
            t = held_values[i];
            if (kept > 0 && (t == held_values[kept-1] || t == prev)) continue;
            j = kept;
            while (j > 0 && t < held_values[j-1]) begin
               held_values[j] = held_values[j-1];
               j--;
            end
            held_values[j] = t;
            prev = t;
            kept++;
         end
      end
      for (int k = 0; k < kept; k++) begin
         w.sorted_value = held_values[k];
         w.last_result = (k + 1 == kept);
         w.kept_count = KEPT_W'(kept);
         w.overflow = dropped_extra;
         expected_words.push_back(w);
      end
      held_count = 0;
      dropped_extra = 1'b0;
   endfunction

   task automatic send_word(logic [VAL_W-1:0] value, logic last_item, bit no_gaps);
      while (!no_gaps && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      req_ch.last_item <= last_item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      accept_value(value, last_item);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic void add_row(logic [VAL_W-1:0] value, logic last_item);
      stim_row_type r;
      r.value = value; r.last_item = last_item; r.typed = 1'b0;
      rows.push_back(r);
   endfunction

   function automatic void add_typed(logic [VAL_W-1:0] value, logic [KEPT_W-1:0] kept,
                                     logic ovf);
      stim_row_type r;
      r.value = value; r.last_item = 1'b1; r.typed = 1'b1;
      r.sorted_value = value; r.kept_count = kept; r.overflow = ovf;
      rows.push_back(r);
   endfunction

   // The held-off stretch counts the cycles in which a result word is waiting.
   always @(posedge clock) begin
      if (hold_sink && rsp_ch.valid) begin
         if (hold_cycles == 249) begin
            hold_sink <= 1'b0;
            hold_cycles <= 0;
         end else begin
            hold_cycles <= hold_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !hold_sink && (quiet_sink || $urandom_range(99) >= 9);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_ch.sorted_value);
               error_count++;
            end else begin
               sorted_word_type e;
               e = expected_words.pop_front();
               if (rsp_ch.sorted_value !== e.sorted_value || rsp_ch.last_result !== e.last_result
                   || rsp_ch.kept_count !== e.kept_count || rsp_ch.overflow !== e.overflow) begin
                  $display("%0t: expected %h/%b/%0d/%b actual %h/%b/%0d/%b", $time,
                           e.sorted_value, e.last_result, e.kept_count, e.overflow,
                           rsp_ch.sorted_value, rsp_ch.last_result, rsp_ch.kept_count,
                           rsp_ch.overflow);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("[introsort_u32_dedup_top] ERROR");
      $finish;
   end

   initial begin
      int n, sent;
      logic [VAL_W-1:0] v;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.last_item = 1'b0;
      held_count = 0;
      dropped_extra = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single words pass straight through, with the field extremes; a five-word set with a repeat follows.
      add_typed(32'h0000_0000, 7'd1, 1'b0);
      add_typed(32'hFFFF_FFFF, 7'd1, 1'b0);
      add_typed(32'hAAAA_AAAA, 7'd1, 1'b0);
      add_row(32'h5555_5555, 1'b0);
      add_row(32'hFFFF_FFFF, 1'b0);
      add_row(32'h0000_0000, 1'b0);
      add_row(32'h5555_5555, 1'b0);
      add_row(32'h8000_0000, 1'b1);
      foreach (rows[i]) begin
         send_word(rows[i].value, rows[i].last_item, 1'b0);
         if (rows[i].typed) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            if (expected_words.size() != 1 || expected_words[0].sorted_value !== rows[i].sorted_value
                || expected_words[0].kept_count !== rows[i].kept_count
                || expected_words[0].overflow !== rows[i].overflow) begin
               $display("%0t: expected %h/%0d/%b from the single word case", $time,
                        rows[i].sorted_value, rows[i].kept_count, rows[i].overflow);
               error_count++;
            end
         end
      end
      wait_drained();

      // A full store plus extras sets overflow; the sink holds off while the
      // next set keeps waiting at the input.
      hold_sink = 1'b1;
      for (int i = 0; i < DEPTH_DEF + 2; i++) send_word($urandom, i == DEPTH_DEF + 1, 1'b1);
      for (int i = 0; i < 6; i++) send_word($urandom_range(3), i == 5, 1'b1);
      wait_drained();

      sent = 0;
      while (sent < 90) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(20, 64) : $urandom_range(2, 12);
         quiet_sink = ($urandom_range(5) == 0);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: v = $urandom_range(7);
               1: v = 32'hFFFF_FFF0 | $urandom_range(15);
               default: v = $urandom;
            endcase
            send_word(v, i == n - 1, quiet_sink);
         end
         sent += n;
         if ($urandom_range(3) == 0) wait_drained();
      end
      quiet_sink = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("[introsort_u32_dedup_top] OK");
      else
         $display("[introsort_u32_dedup_top] ERROR");
      $finish;
   end
endmodule

/* introsort_u32_dedup_top.f */
+incdir+rtl
rtl/iso_pkg.sv
rtl/iso_if.sv
rtl/iso_store.sv
rtl/iso_engine.sv
rtl/introsort_u32_dedup_top.sv
dv/introsort_u32_dedup_top_test.sv
